@@ hdl/flcf_pkg.sv @@
// Shared widths and register indexes for the full linear convolution FIR.
package flcf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int TAP_W      = 16;
  localparam int PROD_W     = SAMPLE_W + TAP_W;
  localparam int RESULT_W   = 35;
  localparam int LEN_W      = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int TAP_SLOTS  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_WORD_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_WORD_HIGH = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [TAP_W-1:0]    tap_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [RESULT_W-1:0] result_t;

  // Control that travels alongside the datapath stages.
  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

@@ hdl/full_linear_convolution_fir_top.sv @@
// Full linear convolution FIR: delay line, tail flush sequencer and output handshake.
//
// Streaming direct-form FIR that computes the full linear convolution of a
// Q1.15 sample stream with a kernel of up to MAX_TAPS Q1.15 taps. One sample
// is taken per cycle unless the pipeline stalls or a tail flush runs, and
// yields one exact 35-bit result with 30 fractional bits. A sample flagged
// end_of_signal is followed by kernel_length-1 tail results, produced one
// per cycle while the output is not stalled, by shifting zeros through the
// delay line; input is held off during the flush. The delay line is then
// cleared and the next signal starts from zeros. The result passes a
// register after the tap multipliers and another after the adder tree. A
// stalled output stalls the whole pipeline. kernel_length 0 acts as 1 and
// values above MAX_TAPS act as MAX_TAPS. Configuration writes take effect
// at once and belong between signals, while the pipeline is empty.
module full_linear_convolution_fir_top #(
  parameter int MAX_TAPS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [flcf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [flcf_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [flcf_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 end_of_signal_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [flcf_pkg::RESULT_W-1:0] result_o,
  output logic                                 final_result_o
);

  localparam int DlDepth = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
  localparam logic [flcf_pkg::LEN_W-1:0] MaxLen = flcf_pkg::LEN_W'(MAX_TAPS);
  localparam logic [flcf_pkg::LEN_W-1:0] OneLen = flcf_pkg::LEN_W'(1);

  logic [flcf_pkg::LEN_W-1:0]      klen_q;
  logic [flcf_pkg::CFG_DATA_W-1:0] tap_lo_q;
  logic [flcf_pkg::CFG_DATA_W-1:0] tap_hi_q;

  flcf_pkg::sample_t win_q [DlDepth];
  flcf_pkg::sample_t win_d [DlDepth];
  flcf_pkg::sample_t step_win [MAX_TAPS];
  flcf_pkg::tap_t    tap_eff [MAX_TAPS];

  logic                       flush_q;
  logic [flcf_pkg::LEN_W-1:0] flush_cnt_q;
  flcf_pkg::ctl_t             s1_q;
  flcf_pkg::ctl_t             out_q;

  logic [flcf_pkg::LEN_W-1:0]             len;
  logic [2*flcf_pkg::CFG_DATA_W-1:0]      tap_all;
  logic                                   en;
  logic                                   in_xfer;
  logic                                   step;
  logic                                   step_final;
  logic                                   start_flush;
  flcf_pkg::sample_t                      step_sample;
  flcf_pkg::result_t                      sum;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q   <= OneLen;
      tap_lo_q <= '0;
      tap_hi_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        flcf_pkg::REG_KERNEL_LENGTH: klen_q   <= cfg_data_i[flcf_pkg::LEN_W-1:0];
        flcf_pkg::REG_TAP_WORD_LOW:  tap_lo_q <= cfg_data_i;
        flcf_pkg::REG_TAP_WORD_HIGH: tap_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (klen_q == '0) begin
      len = OneLen;
    end else if (klen_q > MaxLen) begin
      len = MaxLen;
    end else begin
      len = klen_q;
    end
  end

  // Pipeline advances whenever the output slot is free or being drained.
  assign en          = !out_q.valid || out_ready_i;
  assign in_ready_o  = en && !flush_q;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign step        = in_xfer || (flush_q && en);
  assign step_sample = flush_q ? '0 : sample_i;
  assign step_final  = flush_q ? (flush_cnt_q == len - OneLen)
                               : (end_of_signal_i && len == OneLen);
  assign start_flush = in_xfer && end_of_signal_i && len != OneLen;

  assign tap_all = {tap_hi_q, tap_lo_q};

  always_comb begin
    for (int k = 0; k < MAX_TAPS; k++) begin
      step_win[k] = (k == 0) ? step_sample : win_q[(k > 0) ? k - 1 : 0];
      tap_eff[k]  = (flcf_pkg::LEN_W'(k) < len) ?
                    flcf_pkg::tap_t'(tap_all[k*flcf_pkg::TAP_W +: flcf_pkg::TAP_W]) : '0;
    end
  end

  always_comb begin
    win_d = win_q;
    if (step) begin
      for (int j = 0; j < MAX_TAPS - 1; j++) begin
        win_d[j] = step_final ? '0 : step_win[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < DlDepth; j++) begin
        win_q[j] <= '0;
      end
    end else begin
      win_q <= win_d;
    end
  end

  // Tail flush sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flush_q     <= 1'b0;
      flush_cnt_q <= '0;
    end else if (start_flush) begin
      flush_q     <= 1'b1;
      flush_cnt_q <= OneLen;
    end else if (flush_q && en) begin
      if (step_final) begin
        flush_q <= 1'b0;
      end else begin
        flush_cnt_q <= flush_cnt_q + OneLen;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= '0;
      out_q <= '0;
    end else if (en) begin
      s1_q.valid <= step;
      s1_q.last  <= step && step_final;
      out_q      <= s1_q;
    end
  end

  flcf_mac #(
    .MAX_TAPS(MAX_TAPS)
  ) u_mac (
    .clk_i (clk_i),
    .en_i  (en),
    .tap_i (tap_eff),
    .win_i (step_win),
    .sum_o (sum)
  );

  assign out_valid_o    = out_q.valid;
  assign final_result_o = out_q.last;
  assign result_o       = sum;

endmodule

@@ hdl/flcf_mac.sv @@
// Multiply-accumulate datapath: registered tap products, then a registered sum.
module flcf_mac #(
  parameter int MAX_TAPS = 8
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  flcf_pkg::tap_t    tap_i [MAX_TAPS],
  input  flcf_pkg::sample_t win_i [MAX_TAPS],
  output flcf_pkg::result_t sum_o
);

  flcf_pkg::prod_t   prod_q [MAX_TAPS];
  flcf_pkg::prod_t   prod_d [MAX_TAPS];
  flcf_pkg::result_t sum_q;
  flcf_pkg::result_t sum_d;

  always_comb begin
    for (int k = 0; k < MAX_TAPS; k++) begin
      prod_d[k] = tap_i[k] * win_i[k];
    end
  end

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < MAX_TAPS; k++) begin
      sum_d = sum_d + flcf_pkg::result_t'(prod_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      sum_q  <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

@@ bench/full_linear_convolution_fir_top_tb.sv @@
// Self-checking testbench for the full linear convolution FIR top level.
module full_linear_convolution_fir_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned RANDOM_ITEMS = 290;
  localparam int unsigned IDLE_PCT     = 32;

  // Index with no register behind it; writes there must be dropped.
  localparam logic [flcf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    flcf_pkg::result_t value;
    logic              closing;
  } fir_out_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [flcf_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [flcf_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                            in_valid_i;
  logic                            in_ready_o;
  flcf_pkg::sample_t               sample_i;
  logic                            end_of_signal_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  flcf_pkg::result_t               result_o;
  logic                            final_result_o;

  // Predictor state, mirrored from the register writes and sample transfers.
  logic [flcf_pkg::LEN_W-1:0]      kern_len;
  logic [flcf_pkg::CFG_DATA_W-1:0] taps_lo;
  logic [flcf_pkg::CFG_DATA_W-1:0] taps_hi;
  flcf_pkg::sample_t               history [flcf_pkg::TAP_SLOTS];

  fir_out_t    fir_expected_q[$];
  fir_out_t    oldest;
  int unsigned mismatches   = 0;
  int unsigned items_sent   = 0;
  int unsigned hold_left    = 0;
  bit          src_idle_en  = 1'b1;
  bit          sink_idle_en = 1'b1;

  full_linear_convolution_fir_top #(
    .MAX_TAPS(flcf_pkg::TAP_SLOTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .end_of_signal_i(end_of_signal_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_o       (result_o),
    .final_result_o (final_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("full_linear_convolution_fir_top_tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic flcf_pkg::result_t fir_sum(int n);
    logic signed [63:0] acc;
    logic [63:0]        word;
    flcf_pkg::tap_t     coef;
    acc = '0;
    for (int k = 0; k < n; k++) begin
      word = (k < 4) ? taps_lo : taps_hi;
      coef = word[(k % 4) * flcf_pkg::TAP_W +: flcf_pkg::TAP_W];
      acc += coef * history[k];
    end
    return acc[flcf_pkg::RESULT_W-1:0];
  endfunction

  task automatic shift_in(flcf_pkg::sample_t s);
    for (int i = flcf_pkg::TAP_SLOTS - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = s;
  endtask

  task automatic convolve_sample(flcf_pkg::sample_t s, logic eos);
    int       n;
    fir_out_t o;
    n = (kern_len == 0) ? 1 :
        (kern_len > flcf_pkg::TAP_SLOTS) ? flcf_pkg::TAP_SLOTS : int'(kern_len);
    shift_in(s);
    o.value   = fir_sum(n);
    o.closing = eos && (n == 1);
    fir_expected_q = {fir_expected_q, o};
    if (eos) begin
      // tail flush: zeros shifted in, then the line starts clean
      for (int t = 1; t < n; t++) begin
        shift_in('0);
        o.value   = fir_sum(n);
        o.closing = (t == n - 1);
        fir_expected_q = {fir_expected_q, o};
      end
      for (int i = 0; i < flcf_pkg::TAP_SLOTS; i++) history[i] = '0;
    end
  endtask

  // Tracks config and sample transfers, checks each result transfer.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      kern_len = 4'd1;
      taps_lo  = '0;
      taps_hi  = '0;
      for (int i = 0; i < flcf_pkg::TAP_SLOTS; i++) history[i] = '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          flcf_pkg::REG_KERNEL_LENGTH: kern_len = cfg_data_i[flcf_pkg::LEN_W-1:0];
          flcf_pkg::REG_TAP_WORD_LOW:  taps_lo  = cfg_data_i;
          flcf_pkg::REG_TAP_WORD_HIGH: taps_hi  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) convolve_sample(sample_i, end_of_signal_i);
      if (out_valid_o && out_ready_i) begin
        if (fir_expected_q.size() == 0) begin
          $error("unexpected result transfer: result %0d final_result %0b",
                 result_o, final_result_o);
          mismatches++;
        end else begin
          oldest = fir_expected_q.pop_front();
          if (result_o !== oldest.value) begin
            $error("result: expected %0d, actual %0d", oldest.value, result_o);
            mismatches++;
          end
          if (final_result_o !== oldest.closing) begin
            $error("final_result: expected %0b, actual %0b", oldest.closing,
                   final_result_o);
            mismatches++;
          end
        end
      end
    end
  end

  // Receiver: random idling, or a long hold-off when asked.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (sink_idle_en) begin
        out_ready_i <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] rand_q15();
    unique case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_tap_word();
    return {rand_q15(), rand_q15(), rand_q15(), rand_q15()};
  endfunction

  // Holds valid until the transfer; valid stays high into the next item.
  task automatic send_item(logic [15:0] s, logic eos);
    while (src_idle_en && ($urandom_range(99) < IDLE_PCT)) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    sample_i        <= s;
    end_of_signal_i <= eos;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (fir_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [flcf_pkg::CFG_IDX_W-1:0] idx,
                           logic [flcf_pkg::CFG_DATA_W-1:0] data);
    wait_drain();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_kernel(logic [flcf_pkg::LEN_W-1:0] len, logic [63:0] lo,
                                logic [63:0] hi);
    cfg_write(flcf_pkg::REG_KERNEL_LENGTH, 64'(len));
    cfg_write(flcf_pkg::REG_TAP_WORD_LOW, lo);
    cfg_write(flcf_pkg::REG_TAP_WORD_HIGH, hi);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_state();
    // one tap of zero: all results zero, final flag on the last sample's own result
    send_item(16'h7FFF, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h1234, 1'b1);
  endtask

  task automatic test_corner_kernels();
    // most negative taps and samples: largest positive sum
    program_kernel(4'd8, {4{16'h8000}}, {4{16'h8000}});
    for (int i = 0; i < 8; i++) send_item(16'h8000, i == 7);
    program_kernel(4'd8, {4{16'h7FFF}}, {4{16'h7FFF}});
    send_item(16'h7FFF, 1'b0);
    send_item(16'h8000, 1'b1);
    // single tap with end of signal
    program_kernel(4'd1, {48'h0, 16'h7FFF}, rand_tap_word());
    send_item(16'h8000, 1'b1);
    // length zero acts as one
    cfg_write(flcf_pkg::REG_KERNEL_LENGTH, 64'd0);
    send_item(16'h4000, 1'b0);
    send_item(16'hC000, 1'b1);
    // length above the tap count acts as the full tap count
    program_kernel(4'd15, rand_tap_word(), rand_tap_word());
    send_item(rand_q15(), 1'b0);
    send_item(rand_q15(), 1'b0);
    send_item(rand_q15(), 1'b1);
    // write to the unused index must not disturb anything
    cfg_write(REG_UNUSED, {$urandom, $urandom});
    send_item(16'h7FFF, 1'b1);
    // taps changed mid-signal: delay line is kept
    program_kernel(4'd4, rand_tap_word(), rand_tap_word());
    send_item(rand_q15(), 1'b0);
    send_item(rand_q15(), 1'b0);
    cfg_write(flcf_pkg::REG_TAP_WORD_LOW, rand_tap_word());
    send_item(rand_q15(), 1'b0);
    send_item(rand_q15(), 1'b1);
  endtask

  task automatic test_backpressure();
    program_kernel(4'd8, rand_tap_word(), rand_tap_word());
    // receiver holds off while the sender keeps offering
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) send_item(rand_q15(), (i % 13) == 12);
    // sender pauses mid-signal until all results are out
    wait_drain();
    for (int i = 0; i < 10; i++) send_item(rand_q15(), i == 9);
  endtask

  task automatic test_random_signals();
    int unsigned                start;
    int unsigned                sig_len;
    int unsigned                n_sig;
    int unsigned                phase;
    logic [flcf_pkg::LEN_W-1:0] len;
    start = items_sent;
    phase = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      wait_drain();
      src_idle_en  = (phase != 3);
      sink_idle_en = (phase != 3);
      if ($urandom_range(5) == 0) len = flcf_pkg::LEN_W'($urandom_range(15));
      else len = flcf_pkg::LEN_W'($urandom_range(flcf_pkg::TAP_SLOTS, 1));
      if (phase % 4 == 1) begin
        // taps only: an open signal from the last phase carries over
        cfg_write(flcf_pkg::REG_TAP_WORD_LOW, rand_tap_word());
        cfg_write(REG_UNUSED, {$urandom, $urandom});
      end else begin
        program_kernel(len, rand_tap_word(), rand_tap_word());
      end
      n_sig = (phase == 3) ? 8 : $urandom_range(4, 1);
      repeat (n_sig) begin
        sig_len = $urandom_range(12, 1);
        for (int i = 1; i <= sig_len; i++)
          send_item(rand_q15(), (i == sig_len) || ($urandom_range(19) == 0));
      end
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(5, 1)) send_item(rand_q15(), 1'b0);
      phase++;
    end
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    sample_i        = '0;
    end_of_signal_i = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_corner_kernels();
    test_backpressure();
    test_random_signals();
    wait_drain();

    if (mismatches == 0 && fir_expected_q.size() == 0) begin
      $display("full_linear_convolution_fir_top_tb: PASS");
    end else begin
      $display("full_linear_convolution_fir_top_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/flcf_pkg.sv
hdl/flcf_mac.sv
hdl/full_linear_convolution_fir_top.sv
bench/full_linear_convolution_fir_top_tb.sv
